/* rtl/nrvlz_pkg.sv */
// Shared types, constants and method decode for the NRV stream decompressor.
package nrvlz_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       copy_pending;
    logic       done_res;
    logic [2:0] error_code;
  } res_item_t;

  typedef struct packed {
    logic [3:0]  method;
    logic [31:0] output_length;
  } cfg_t;

  localparam logic CMD_BYTE = 1'b0;

  localparam logic REG_METHOD        = 1'b0;
  localparam logic REG_OUTPUT_LENGTH = 1'b1;

  localparam logic [3:0] METHOD_RESET = 4'd2;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED   = 3'd1;
  localparam logic [2:0] ERR_OFF_RUNAWAY = 3'd2;
  localparam logic [2:0] ERR_LEN_RUNAWAY = 3'd3;
  localparam logic [2:0] ERR_BAD_OFFSET  = 3'd4;
  localparam logic [2:0] ERR_OVERRUN     = 3'd5;
  localparam logic [2:0] ERR_EARLY_END   = 3'd6;

  localparam logic [33:0] MAX_OFF_CODE = 34'h0_0100_0002;
  localparam logic [41:0] END_MARK     = 42'h000_ffff_ffff;
  localparam logic [33:0] THR_B        = 34'h0_0000_0d00;
  localparam logic [33:0] THR_DE       = 34'h0_0000_0500;
  localparam logic [31:0] LEN_LIMIT    = 32'h4000_0000;

  localparam logic [1:0] FAM_B = 2'd0;
  localparam logic [1:0] FAM_D = 2'd1;
  localparam logic [1:0] FAM_E = 2'd2;

  function automatic logic [1:0] method_family(input logic [3:0] m);
    logic [1:0] f;
    case (m) inside
      [4'd0:4'd4]: f = FAM_B;
      [4'd5:4'd7]: f = FAM_D;
      default:     f = FAM_E;
    endcase
    return f;
  endfunction

  function automatic logic [2:0] word_bytes(input logic [3:0] m);
    logic [2:0] w;
    case (m) inside
      [4'd0:4'd2], 4'd5, 4'd8: w = 3'd4;
      4'd3, 4'd6, 4'd9:        w = 3'd1;
      default:                 w = 3'd2;
    endcase
    return w;
  endfunction

endpackage

/* rtl/nrv_lz_decompressor.sv */
// Top level: configuration registers, result register and decode core.
//
//   channel | signals                         | transfer when
//   --------+---------------------------------+----------------------
//   input   | in_valid, in_ready, in_item     | in_valid && in_ready
//   result  | res_valid, res_ready, res_item  | res_valid && res_ready
//   config  | cfg_we, cfg_index, cfg_data     | cfg_we
//
// Each item runs through S_RUN decode steps (one stream bit, one refill byte or one
// literal/escape byte per cycle; a copied byte goes through S_RUN and then S_RD, via the
// history memory read port) and then S_OUT. While input flows an item needs at most about
// 35 steps for a 32-bit word; once the last byte is in, zero-filled refills let one tick
// run a whole runaway code, roughly 100 steps.
// A new item is taken while the previous result waits in the result register.
// Reset clears all decode state; the history memory is not cleared.
module nrv_lz_decompressor import nrvlz_pkg::*; #(
  parameter int WINDOW_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        res_valid,
  input  logic        res_ready,
  output res_item_t   res_item
);

  cfg_t      cfg;
  logic      core_idle;
  logic      core_load;
  logic      out_free;
  res_item_t core_res;

  assign in_ready = core_idle;
  assign out_free = !res_valid || res_ready;

  nrvlz_core #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (in_valid && core_idle),
    .item     (in_item),
    .idle     (core_idle),
    .out_free (out_free),
    .res_load (core_load),
    .res_data (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.method        <= METHOD_RESET;
      cfg.output_length <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_METHOD:        cfg.method <= cfg_data[3:0];
          REG_OUTPUT_LENGTH: cfg.output_length <= cfg_data;
          default:           cfg.method <= cfg.method;
        endcase
      end
      if (core_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (core_load) begin
      res_item <= core_res;
    end
  end

endmodule

/* rtl/nrvlz_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nrvlz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/nrvlz_core.sv */
// Bit-serial decode sequencer with history window memory.
module nrvlz_core import nrvlz_pkg::*; #(
  parameter int WINDOW_DEPTH = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      start,
  input  in_item_t  item,
  output logic      idle,
  input  logic      out_free,
  output logic      res_load,
  output res_item_t res_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_DEPTH - 1);
  localparam logic [AW:0]   WIN_EXT  = (AW+1)'(WINDOW_DEPTH);
  localparam logic [33:0]   WIN_34   = 34'(WINDOW_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_RD, S_OUT} state_t;
  typedef enum logic [3:0] {
    PH_FLAG, PH_LIT, PH_OFF_A, PH_OFF_B, PH_OFF_C, PH_ESC,
    PH_LEN_X, PH_LEN_Y, PH_LEN_E1, PH_LEN_E3, PH_G_A, PH_G_B
  } phase_t;

  state_t        state, state_next;
  phase_t        phase, phase_next;
  logic [31:0]   produced, produced_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [33:0]   prev_off, prev_off_next;
  logic [31:0]   word, word_next;
  logic [5:0]    bits, bits_next;
  logic [1:0]    gathered, gathered_next;
  logic [33:0]   off_acc, off_acc_next;
  logic [30:0]   len_acc, len_acc_next;
  logic [31:0]   copy_rem, copy_rem_next;
  logic [AW-1:0] copy_src, copy_src_next;
  logic          ended, ended_next;
  logic [2:0]    err, err_next;
  logic          have, have_next;
  logic [7:0]    in_byte_r;
  logic          in_last_r;
  logic          produced_flag, produced_flag_next;
  logic [7:0]    ob, ob_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [1:0]    fam;
  logic [2:0]    wb;
  logic [5:0]    bit_idx;
  logic          b;
  logic          fin_do;
  logic [30:0]   fin_len;
  logic [31:0]   fin_len2;
  logic [31:0]   fin_count;
  logic [33:0]   thr;
  logic [AW:0]   src_diff;
  logic [41:0]   esc_v;
  logic [33:0]   acc_sh;
  logic [33:0]   acc_c;
  logic [31:0]   g_v;
  logic [31:0]   word_base;
  logic [2:0]    g3;
  logic          ended_tmp;
  logic          pending;

  nrvlz_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (copy_src),
    .rdata (ram_rdata)
  );

  assign fam     = method_family(cfg.method);
  assign wb      = word_bytes(cfg.method);
  assign bit_idx = bits - 6'd1;
  assign b       = word[bit_idx[4:0]];
  assign thr     = (fam == FAM_B) ? THR_B : THR_DE;
  assign esc_v   = {off_acc - 34'd3, in_byte_r};
  assign acc_sh  = {off_acc[32:0], b};
  assign acc_c   = {off_acc[32:0] - 33'd1, b};
  assign g_v     = {len_acc, b};
  assign idle    = (state == S_IDLE);

  assign fin_len2  = {1'b0, fin_len} + ((off_acc > thr) ? 32'd1 : 32'd0);
  assign fin_count = fin_len2 + 32'd1;
  assign src_diff  = {1'b0, wr_ptr} - off_acc[AW:0];

  assign pending = (err == ERR_NONE) && (produced < cfg.output_length) &&
                   ((copy_rem != 32'd0) || ended ||
                    (phase != PH_LIT && phase != PH_ESC && bits != 6'd0));

  always_comb begin
    res_data.out_byte     = produced_flag ? ob : 8'd0;
    res_data.out_valid    = produced_flag;
    res_data.copy_pending = pending;
    res_data.done_res     = (err == ERR_NONE) && (produced == cfg.output_length);
    res_data.error_code   = err;
  end

  always_comb begin
    state_next         = state;
    phase_next         = phase;
    produced_next      = produced;
    wr_ptr_next        = wr_ptr;
    prev_off_next      = prev_off;
    word_next          = word;
    bits_next          = bits;
    gathered_next      = gathered;
    off_acc_next       = off_acc;
    len_acc_next       = len_acc;
    copy_rem_next      = copy_rem;
    copy_src_next      = copy_src;
    ended_next         = ended;
    err_next           = err;
    have_next          = have;
    produced_flag_next = produced_flag;
    ob_next            = ob;
    ram_we             = 1'b0;
    ram_waddr          = wr_ptr;
    ram_wdata          = in_byte_r;
    res_load           = 1'b0;
    fin_do             = 1'b0;
    fin_len            = len_acc;
    word_base          = (gathered == 2'd0) ? 32'd0 : word;
    g3                 = {1'b0, gathered};
    ended_tmp          = ended;

    case (state)
      S_IDLE: begin
        if (start) begin
          have_next          = (item.command == CMD_BYTE) && !ended;
          produced_flag_next = 1'b0;
          state_next         = S_RUN;
        end
      end
      S_RUN: begin
        if (err != ERR_NONE) begin
          state_next = S_OUT;
        end else if (produced >= cfg.output_length) begin
          if (produced > cfg.output_length) err_next = ERR_OVERRUN;
          state_next = S_OUT;
        end else if (produced_flag) begin
          state_next = S_OUT;
        end else if (copy_rem != 32'd0) begin
          state_next = S_RD;
        end else if (phase == PH_LIT || phase == PH_ESC) begin
          if (!have) begin
            if (ended) err_next = ERR_TRUNCATED;
            state_next = S_OUT;
          end else begin
            have_next = 1'b0;
            if (in_last_r) ended_next = 1'b1;
            if (phase == PH_LIT) begin
              ram_we             = 1'b1;
              ob_next            = in_byte_r;
              produced_next      = produced + 32'd1;
              wr_ptr_next        = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
              produced_flag_next = 1'b1;
              phase_next         = PH_FLAG;
            end else if (esc_v == END_MARK) begin
              err_next = ERR_EARLY_END;
            end else if (fam == FAM_B) begin
              off_acc_next  = 34'(esc_v + 42'd1);
              prev_off_next = 34'(esc_v + 42'd1);
              phase_next    = PH_LEN_X;
            end else begin
              len_acc_next  = {30'd0, ~esc_v[0]};
              off_acc_next  = esc_v[34:1] + 34'd1;
              prev_off_next = esc_v[34:1] + 34'd1;
              phase_next    = (fam == FAM_E) ? PH_LEN_E1 : PH_LEN_Y;
            end
          end
        end else if (bits == 6'd0) begin
          if (have) begin
            word_next = word_base | (32'(in_byte_r) << {gathered, 3'b000});
            g3        = {1'b0, gathered} + 3'd1;
            have_next = 1'b0;
            if (in_last_r) ended_tmp = 1'b1;
          end else begin
            word_next = word_base;
          end
          if (!have && !ended) begin
            word_next  = word;
            state_next = S_OUT;
          end else begin
            ended_next = ended_tmp;
            if (g3 >= wb || ended_tmp) begin
              bits_next     = {wb, 3'b000};
              gathered_next = 2'd0;
            end else begin
              gathered_next = g3[1:0];
            end
          end
        end else begin
          bits_next = bit_idx;
          case (phase)
            PH_FLAG: begin
              if (b) begin
                phase_next = PH_LIT;
              end else begin
                off_acc_next = 34'd1;
                phase_next   = PH_OFF_A;
              end
            end
            PH_OFF_A: begin
              off_acc_next = acc_sh;
              if (fam == FAM_B && acc_sh > MAX_OFF_CODE) err_next = ERR_OFF_RUNAWAY;
              else phase_next = PH_OFF_B;
            end
            PH_OFF_B: begin
              if (b) begin
                if (off_acc == 34'd2) begin
                  off_acc_next = prev_off;
                  phase_next   = PH_LEN_X;
                end else begin
                  phase_next = PH_ESC;
                end
              end else begin
                phase_next = (fam == FAM_B) ? PH_OFF_A : PH_OFF_C;
              end
            end
            PH_OFF_C: begin
              off_acc_next = acc_c;
              if (acc_c > MAX_OFF_CODE) err_next = ERR_OFF_RUNAWAY;
              else phase_next = PH_OFF_A;
            end
            PH_LEN_X: begin
              len_acc_next = {30'd0, b};
              phase_next   = (fam == FAM_E) ? PH_LEN_E1 : PH_LEN_Y;
            end
            PH_LEN_Y: begin
              if ({len_acc[29:0], b} == 31'd0) begin
                len_acc_next = 31'd1;
                phase_next   = PH_G_A;
              end else begin
                len_acc_next = {len_acc[29:0], b};
                fin_len      = {len_acc[29:0], b};
                fin_do       = 1'b1;
              end
            end
            PH_LEN_E1: begin
              if (len_acc != 31'd0) begin
                fin_len = 31'd1 + {30'd0, b};
                fin_do  = 1'b1;
              end else if (b) begin
                phase_next = PH_LEN_E3;
              end else begin
                len_acc_next = 31'd1;
                phase_next   = PH_G_A;
              end
            end
            PH_LEN_E3: begin
              fin_len = 31'd3 + {30'd0, b};
              fin_do  = 1'b1;
            end
            PH_G_A: begin
              if (g_v > LEN_LIMIT) begin
                err_next = ERR_LEN_RUNAWAY;
              end else begin
                len_acc_next = g_v[30:0];
                phase_next   = PH_G_B;
              end
            end
            PH_G_B: begin
              if (b) begin
                fin_len = len_acc + ((fam == FAM_E) ? 31'd3 : 31'd2);
                fin_do  = 1'b1;
              end else begin
                phase_next = PH_G_A;
              end
            end
            default: phase_next = PH_FLAG;
          endcase
          if (fin_do) begin
            len_acc_next = fin_len;
            if (off_acc == 34'd0 || off_acc > {2'b00, produced} || off_acc > WIN_34) begin
              err_next = ERR_BAD_OFFSET;
            end else if (fin_count > cfg.output_length - produced) begin
              err_next = ERR_OVERRUN;
            end else begin
              copy_rem_next = fin_count;
              copy_src_next = src_diff[AW] ? AW'(src_diff + WIN_EXT) : src_diff[AW-1:0];
              phase_next    = PH_FLAG;
            end
          end
        end
      end
      S_RD: begin
        ram_we             = 1'b1;
        ram_wdata          = ram_rdata;
        ob_next            = ram_rdata;
        produced_next      = produced + 32'd1;
        wr_ptr_next        = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
        copy_src_next      = (copy_src == PTR_LAST) ? '0 : copy_src + 1'b1;
        copy_rem_next      = copy_rem - 32'd1;
        produced_flag_next = 1'b1;
        state_next         = S_RUN;
      end
      S_OUT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_FLAG;
      produced      <= '0;
      wr_ptr        <= '0;
      prev_off      <= 34'd1;
      word          <= '0;
      bits          <= '0;
      gathered      <= '0;
      off_acc       <= 34'd1;
      len_acc       <= '0;
      copy_rem      <= '0;
      copy_src      <= '0;
      ended         <= 1'b0;
      err           <= ERR_NONE;
      have          <= 1'b0;
      produced_flag <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      produced      <= produced_next;
      wr_ptr        <= wr_ptr_next;
      prev_off      <= prev_off_next;
      word          <= word_next;
      bits          <= bits_next;
      gathered      <= gathered_next;
      off_acc       <= off_acc_next;
      len_acc       <= len_acc_next;
      copy_rem      <= copy_rem_next;
      copy_src      <= copy_src_next;
      ended         <= ended_next;
      err           <= err_next;
      have          <= have_next;
      produced_flag <= produced_flag_next;
    end
    ob <= ob_next;
    if (state == S_IDLE && start) begin
      in_byte_r <= item.in_byte;
      in_last_r <= item.in_last;
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the NRV2B/D/E stream decompressor with its own stream encoder.
module tb_top import nrvlz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WIN        = 65536;
  localparam logic        CMD_TICK   = 1'b1;
  localparam longint unsigned OFF_CODE_MAX = 64'h00ff_ffff + 3;
  localparam longint unsigned ESC_END  = 64'hffff_ffff;
  localparam longint unsigned THRESH_B = 64'hd00;
  localparam longint unsigned THRESH_DE = 64'h500;
  localparam longint unsigned GAMMA_MAX = 64'h4000_0000;
  localparam int          CYCLE_LIMIT = 3000000;
  localparam int          NPHASE     = 40;

  typedef enum int {
    ST_FLAG, ST_LIT, ST_OFF_A, ST_OFF_B, ST_OFF_C, ST_ESC,
    ST_LEN_X, ST_LEN_Y, ST_LEN_E1, ST_LEN_E3, ST_G_A, ST_G_B
  } dec_state_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_METHOD;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_item_t   res_item;

  nrv_lz_decompressor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  always #4 clk = ~clk;

  // decoder state mirror
  logic [7:0]      hist [WIN];
  logic [3:0]      cfg_method = METHOD_RESET;
  bit [31:0]       cfg_olen = '0;
  bit [31:0]       produced = '0;
  longint unsigned prev_off = 1;
  bit [31:0]       bit_word = '0;
  int              bits_left = 0;
  int              gathered = 0;
  dec_state_e      dstate = ST_FLAG;
  longint unsigned off_acc = 1;
  longint unsigned len_acc = 0;
  bit [31:0]       copy_left = '0;
  bit [15:0]       copy_src = '0;
  bit              ended = 1'b0;
  logic [2:0]      err_latch = ERR_NONE;

  in_item_t  item_q [$];
  res_item_t expected_q [$];

  // encoder state
  bit [7:0] zstream [$];
  int       wpos = 0;
  int       wbits = 0;
  int       enc_total = 0;
  int       enc_prev = 1;
  int       sp = 0;

  int n_items = 0;
  int n_checked = 0;
  int n_fail = 0;
  int cycles = 0;

  function automatic int eff_meth(logic [3:0] m);
    return (m < 2) ? 2 : ((m > 10) ? 10 : int'(m));
  endfunction

  function automatic int fam_of(logic [3:0] m);
    return (eff_meth(m) - 2) / 3;
  endfunction

  function automatic int wbytes_of(logic [3:0] m);
    int w;
    w = (eff_meth(m) - 2) % 3;
    return (w == 0) ? 4 : ((w == 1) ? 1 : 2);
  endfunction

  function automatic void put_out(logic [7:0] b);
    hist[produced[15:0]] = b;
    produced++;
  endfunction

  function automatic void finish_match();
    longint unsigned len, thr, cnt;
    bit [31:0] owed, src;
    len = len_acc;
    thr = (fam_of(cfg_method) == 0) ? THRESH_B : THRESH_DE;
    if (off_acc > thr) len++;
    cnt = len + 1;
    owed = cfg_olen - produced;
    if (off_acc == 0 || off_acc > produced || off_acc > WIN) begin
      err_latch = ERR_BAD_OFFSET;
    end else if (cnt > owed) begin
      err_latch = ERR_OVERRUN;
    end else begin
      copy_left = cnt[31:0];
      src = produced - off_acc[31:0];
      copy_src = src[15:0];
      dstate = ST_FLAG;
    end
  endfunction

  function automatic void start_gamma();
    len_acc = 1;
    dstate = ST_G_A;
  endfunction

  function automatic void decode_bit(bit b);
    int fam;
    longint unsigned v;
    fam = fam_of(cfg_method);
    case (dstate)
      ST_FLAG: begin
        if (b) dstate = ST_LIT;
        else begin
          off_acc = 1;
          dstate = ST_OFF_A;
        end
      end
      ST_OFF_A: begin
        off_acc = off_acc * 2 + b;
        if (fam == 0 && off_acc > OFF_CODE_MAX) err_latch = ERR_OFF_RUNAWAY;
        else dstate = ST_OFF_B;
      end
      ST_OFF_B: begin
        if (b) begin
          if (off_acc == 2) begin
            off_acc = prev_off;
            dstate = ST_LEN_X;
          end else dstate = ST_ESC;
        end else dstate = (fam == 0) ? ST_OFF_A : ST_OFF_C;
      end
      ST_OFF_C: begin
        off_acc = (off_acc - 1) * 2 + b;
        if (off_acc > OFF_CODE_MAX) err_latch = ERR_OFF_RUNAWAY;
        else dstate = ST_OFF_A;
      end
      ST_LEN_X: begin
        len_acc = b;
        dstate = (fam == 2) ? ST_LEN_E1 : ST_LEN_Y;
      end
      ST_LEN_Y: begin
        len_acc = len_acc * 2 + b;
        if (len_acc == 0) start_gamma();
        else finish_match();
      end
      ST_LEN_E1: begin
        if (len_acc != 0) begin
          len_acc = 1 + b;
          finish_match();
        end else if (b) dstate = ST_LEN_E3;
        else start_gamma();
      end
      ST_LEN_E3: begin
        len_acc = 3 + b;
        finish_match();
      end
      ST_G_A: begin
        v = len_acc * 2 + b;
        if (v > GAMMA_MAX) err_latch = ERR_LEN_RUNAWAY;
        else begin
          len_acc = v;
          dstate = ST_G_B;
        end
      end
      ST_G_B: begin
        if (b) begin
          len_acc += (fam == 2) ? 3 : 2;
          finish_match();
        end else dstate = ST_G_A;
      end
      default: dstate = ST_FLAG;
    endcase
  endfunction

  function automatic void decode_escape(bit [7:0] by);
    longint unsigned v, off;
    v = (off_acc - 3) * 256 + by;
    if (v == ESC_END) begin
      err_latch = ERR_EARLY_END;
      return;
    end
    if (fam_of(cfg_method) == 0) begin
      off = v + 1;
      dstate = ST_LEN_X;
    end else begin
      len_acc = (~v) & 1;
      off = (v >> 1) + 1;
      dstate = (fam_of(cfg_method) == 2) ? ST_LEN_E1 : ST_LEN_Y;
    end
    prev_off = off;
    off_acc = off;
  endfunction

  // Returns the result of one item; used is set when the byte was consumed.
  function automatic void decode_item(input in_item_t it, output res_item_t r, output bit used);
    bit have, vld, pend;
    logic [7:0] ob;
    int wb;
    have = (it.command == CMD_BYTE) && !ended;
    vld = 1'b0;
    ob = '0;
    used = 1'b0;
    while (1'b1) begin
      if (err_latch != ERR_NONE) break;
      if (produced >= cfg_olen) begin
        if (produced > cfg_olen) err_latch = ERR_OVERRUN;
        break;
      end
      if (vld) break;
      if (copy_left > 0) begin
        ob = hist[copy_src];
        put_out(ob);
        copy_src++;
        copy_left--;
        vld = 1'b1;
        continue;
      end
      if (dstate == ST_LIT || dstate == ST_ESC) begin
        if (!have) begin
          if (ended) err_latch = ERR_TRUNCATED;
          break;
        end
        have = 1'b0;
        used = 1'b1;
        if (it.in_last) ended = 1'b1;
        if (dstate == ST_LIT) begin
          ob = it.in_byte;
          put_out(ob);
          vld = 1'b1;
          dstate = ST_FLAG;
        end else decode_escape(it.in_byte);
        continue;
      end
      if (bits_left == 0) begin
        wb = wbytes_of(cfg_method);
        if (gathered == 0) bit_word = '0;
        if (have) begin
          bit_word |= 32'(it.in_byte) << (8 * (gathered & 3));
          gathered++;
          have = 1'b0;
          used = 1'b1;
          if (it.in_last) ended = 1'b1;
        end else if (!ended) break;
        if (gathered >= wb || ended) begin
          bits_left = wb * 8;
          gathered = 0;
        end
        continue;
      end
      bits_left--;
      decode_bit(bit_word[bits_left]);
    end
    pend = err_latch == ERR_NONE && produced < cfg_olen &&
           (copy_left > 0 || ended ||
            (dstate != ST_LIT && dstate != ST_ESC && bits_left > 0));
    r.out_byte = vld ? ob : 8'h00;
    r.out_valid = vld;
    r.copy_pending = pend;
    r.done_res = (err_latch == ERR_NONE && produced == cfg_olen);
    r.error_code = err_latch;
  endfunction

  function automatic bit send_item(logic cmd, logic [7:0] by, logic last);
    in_item_t it;
    res_item_t r;
    bit used;
    it.command = cmd;
    it.in_byte = by;
    it.in_last = last;
    decode_item(it, r, used);
    item_q = {item_q, it};
    expected_q = {expected_q, r};
    n_items++;
    return used;
  endfunction

  // stream encoder
  function automatic void enc_bit(bit b, logic [3:0] m);
    int idx;
    if (wbits == 0) begin
      wpos = zstream.size();
      wbits = 8 * wbytes_of(m);
      repeat (wbytes_of(m)) zstream = {zstream, 8'h00};
    end
    wbits--;
    idx = wpos + wbits / 8;
    if (b) zstream[idx] = zstream[idx] | (8'h01 << (wbits % 8));
  endfunction

  function automatic void enc_gamma(int g, logic [3:0] m);
    int top;
    top = 31;
    while (!g[top]) top--;
    for (int i = top - 1; i >= 0; i--) begin
      enc_bit(g[i], m);
      enc_bit(i == 0, m);
    end
  endfunction

  function automatic void enc_segment(int n, logic [3:0] m);
    int left, fam, acc, off, cnt, g;
    bit reuse, x, y, c, lb;
    bit [7:0] eb;
    left = n;
    fam = fam_of(m);
    while (left > 0) begin
      g = $urandom_range(2, 7);
      x = 1'($urandom);
      y = 1'($urandom);
      c = 1'($urandom);
      eb = 8'($urandom);
      reuse = $urandom_range(0, 2) == 0;
      if (reuse) begin
        acc = 2;
        off = enc_prev;
      end else if (fam == 0) begin
        acc = $urandom_range(3, 5);
        off = (acc - 3) * 256 + eb + 1;
      end else begin
        acc = 3;
        off = (eb >> 1) + 1;
        lb = ~eb[0];
        x = lb;
      end
      if (fam != 2) cnt = (!x && !y) ? g + 3 : x * 2 + y + 1;
      else cnt = x ? 2 + y : (y ? 4 + c : g + 4);
      if ($urandom_range(0, 2) == 0 || cnt > left || off > enc_total) begin
        enc_bit(1'b1, m);
        zstream = {zstream, 8'($urandom)};
        left--;
        enc_total++;
      end else begin
        enc_bit(1'b0, m);
        enc_gamma(acc, m);
        if (!reuse) begin
          zstream = {zstream, eb};
          enc_prev = off;
        end
        if (fam != 2) begin
          if (reuse || fam == 0) enc_bit(x, m);
          enc_bit(y, m);
          if (!x && !y) enc_gamma(g, m);
        end else begin
          if (reuse) enc_bit(x, m);
          enc_bit(y, m);
          if (!x) begin
            if (y) enc_bit(c, m);
            else enc_gamma(g, m);
          end
        end
        left -= cnt;
        enc_total += cnt;
      end
    end
  endfunction

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_METHOD) cfg_method = val[3:0];
    else cfg_olen = val;
  endtask

  task automatic wait_drain();
    while (item_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // driver: bursts of transfers separated by random gaps
  int gap_left = 0;
  int burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        in_item <= item_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: own stall pattern, compare against oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        n_checked++;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result %p", res_item);
        end else begin
          want = expected_q.pop_front();
          if (res_item.out_byte !== want.out_byte || res_item.out_valid !== want.out_valid ||
              res_item.copy_pending !== want.copy_pending ||
              res_item.done_res !== want.done_res ||
              res_item.error_code !== want.error_code) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result %0d mismatch: byte %h/%h valid %b/%b pend %b/%b done %b/%b err %0d/%0d",
                       n_checked, want.out_byte, res_item.out_byte, want.out_valid,
                       res_item.out_valid, want.copy_pending, res_item.copy_pending,
                       want.done_res, res_item.done_res, want.error_code, res_item.error_code);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (cycles[9] && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  logic [3:0] phase_meth [NPHASE];
  int         phase_len [NPHASE];
  logic [3:0] meth_seed [13] = '{4'd0, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
                                 4'd8, 4'd9, 4'd10, 4'd15, 4'd1, 4'd11};

  initial begin
    bit used;
    int total, n, p;
    bit lowered;
    for (int i = 0; i < WIN; i++) hist[i] = 8'h00;
    total = 0;
    for (int i = 0; i < NPHASE; i++) begin
      phase_meth[i] = (i < 13) ? meth_seed[i] : 4'($urandom);
      phase_len[i] = (i == 2) ? 0 : $urandom_range(10, 60);
      enc_segment(phase_len[i], phase_meth[i]);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero output length: done at once, bytes ignored
    used = send_item(CMD_BYTE, 8'hff, 1'b1);
    used = send_item(CMD_BYTE, 8'h00, 1'b0);
    used = send_item(CMD_TICK, 8'h5a, 1'b1);
    wait_drain();

    p = 0;
    while (p < NPHASE && n_items < 820) begin
      total += phase_len[p];
      write_reg(REG_METHOD, 32'(phase_meth[p]));
      write_reg(REG_OUTPUT_LENGTH, total);
      n = 0;
      while (err_latch == ERR_NONE && produced != cfg_olen && n < 20000) begin
        if (sp < zstream.size() && $urandom_range(0, 3) != 0)
          used = send_item(CMD_BYTE, zstream[sp], 1'b0);
        else
          used = send_item(CMD_TICK, 8'($urandom), 1'($urandom));
        if (used) sp++;
        n++;
      end
      wait_drain();
      p++;
    end

    // closing phase: either shrink the length under the output, or run noise to the end
    lowered = $urandom_range(0, 1) && produced > 0;
    write_reg(REG_METHOD, 32'($urandom_range(0, 15)));
    if (lowered) begin
      write_reg(REG_OUTPUT_LENGTH, produced - 1);
      repeat (3) used = send_item(CMD_TICK, 8'h00, 1'b0);
    end else begin
      write_reg(REG_OUTPUT_LENGTH, 32'hffff_ffff);
      n = 0;
      while (!ended && err_latch == ERR_NONE && n < 40) begin
        used = send_item(CMD_BYTE, 8'($urandom), n >= 20 && $urandom_range(0, 3) == 0);
        n++;
      end
      while (err_latch == ERR_NONE && n < 100) begin
        used = send_item(CMD_TICK, 8'($urandom), 1'($urandom));
        n++;
      end
    end
    wait_drain();

    $display("run: %0d items, %0d results checked, %0d phases of stream data", n_items,
             n_checked, p);
    $display("decoded %0d bytes, closing status code %0d, mismatches %0d", produced,
             err_latch, n_fail);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/nrvlz_pkg.sv
rtl/nrvlz_ram.sv
rtl/nrvlz_core.sv
rtl/nrv_lz_decompressor.sv
test/tb_top.sv
